// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising edge out of reset
`define ASSERT_AT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Check that a condition never holds at a rising edge out of reset
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`endif

// ----- hw/rtl/gbn_pkg.sv -----
// ----------------------------------------------------------------------------
// Go-back-N sender package
// Types and fixed codes shared by the go-back-N sender.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam int unsigned SEQ_W    = 32;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned LEN_W    = 8;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_W    = 4;

  // Input item kinds
  localparam logic [MODE_W-1:0] MODE_SEND    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ACK     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TIMEOUT = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_TX      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADMODE = 2'd2;

  // Window register value after reset
  localparam logic [CFG_W-1:0] WIN_RESET = 4'd4;

  // One queued frame as held in the frame store
  typedef struct packed {
    logic [SEQ_W-1:0]    seq;
    logic [HANDLE_W-1:0] handle;
    logic [LEN_W-1:0]    len;
  } entry_t;

  // Sequencer states
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_ACK    = 6'b000100,
    S_FILL   = 6'b001000,
    S_EMIT   = 6'b010000,
    S_PUT    = 6'b100000
  } state_e;

endpackage

// ----- hw/rtl/gbn_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gbn_ram #(
  parameter int unsigned WIDTH = 56,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write when enabled; read every cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/go_back_n_sender.sv -----
// ----------------------------------------------------------------------------
// Go-back-N sender
// Sliding-window transmit control over a queue of frame handles.
// ----------------------------------------------------------------------------
// Usage: an item enters on the s_axis group; tuser carries the kind (send,
// ack, timeout). Results leave on the m_axis group: a send or a bad kind gives
// at most one result, an ack or a timeout one transmit request per frame sent,
// tlast marking the final result of an input item. The window register is
// written over the cfg channel, which is always ready.
// A send writes the frame store and, while the window has room, moves its
// result through a pending register into the output register; a full queue
// or a bad kind gives an error status the same way. An ack retires
// acknowledged frames from the head, then refills the window from unsent
// frames; a timeout resends every outstanding frame. The per-frame walk is
// set by the single read port of the frame store, which the one compare unit
// and the result path share. s_axis_tready is high only while the sequencer
// is idle, so one item is in work at a time; a send into a full window or a
// timeout with nothing outstanding returns to idle from decode, with no result.
// A stalled receiver holds the output register; the walk pauses until it is
// taken, and a new item may be accepted while the last result still waits.
// Reset empties the queue and sets the window to 4; the frame store is not
// cleared, since an entry is only read after it has been written.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module go_back_n_sender #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned MAX_WINDOW  = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Window register write
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [gbn_pkg::CFG_W-1:0]           cfg_data_i,
  // Input items
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: frame_seq[31:0], frame_handle[47:32], frame_len[55:48],
  //        ack_seq[87:56]
  input  logic [87:0]                         s_axis_tdata,
  // tuser: mode[1:0]
  input  logic [gbn_pkg::MODE_W-1:0]          s_axis_tuser,
  // Result items
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: tx_handle[15:0], tx_len[23:16]
  output logic [23:0]                         m_axis_tdata,
  // tuser: status[1:0]
  output logic [gbn_pkg::STATUS_W-1:0]        m_axis_tuser,
  output logic                                m_axis_tlast
);

  import gbn_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned NW = (CW > CFG_W) ? CW : CFG_W;

  // Wrap a pointer advanced by a count below the queue depth
  function automatic logic [PW-1:0] ptr_add(input logic [PW-1:0] a,
                                            input logic [CW-1:0] b);
    logic [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(b);
    if (s >= (CW+1)'(QUEUE_DEPTH)) begin
      s = s - (CW+1)'(QUEUE_DEPTH);
    end
    return s[PW-1:0];
  endfunction

  state_e            state_q, state_d;
  logic [CFG_W-1:0]  win_cfg_q, win_cfg_d;
  logic [PW-1:0]     head_q, head_d;
  logic [PW-1:0]     tail_q, tail_d;
  logic [PW-1:0]     rd_addr_q, rd_addr_d;
  logic [CW-1:0]     queued_q, queued_d;
  logic [CW-1:0]     outs_q, outs_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              inc_q, inc_d;
  logic              out_valid_q, out_valid_d;

  // Captured input item
  logic [MODE_W-1:0]   in_mode_q;
  logic [SEQ_W-1:0]    in_seq_q;
  logic [HANDLE_W-1:0] in_handle_q;
  logic [LEN_W-1:0]    in_len_q;
  logic [SEQ_W-1:0]    in_ack_q;

  // Single pending result and output register
  logic [STATUS_W-1:0] pend_status_q, pend_status_d;
  logic [HANDLE_W-1:0] pend_handle_q, pend_handle_d;
  logic [LEN_W-1:0]    pend_len_q, pend_len_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [HANDLE_W-1:0] out_handle_q, out_handle_d;
  logic [LEN_W-1:0]    out_len_q, out_len_d;
  logic                out_last_q, out_last_d;

  logic              in_accept;
  logic              out_free;
  logic              ram_we;
  entry_t            ram_wdata;
  entry_t            ram_rdata;
  logic [NW-1:0]     win;
  logic [CFG_W-1:0]  win_lo;
  logic [NW-1:0]     room;
  logic [NW-1:0]     avail;
  logic [NW-1:0]     num;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_len_q, out_handle_q};
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

  // Clamp the window register to 1..MAX_WINDOW
  always_comb begin
    win_lo = (win_cfg_q == '0) ? CFG_W'(1) : win_cfg_q;
    if (int'(win_lo) > int'(MAX_WINDOW)) begin
      win = NW'(MAX_WINDOW);
    end else begin
      win = NW'(win_lo);
    end
  end

  // Refill amount: frames queued but not sent, bounded by window room
  always_comb begin
    avail = NW'(queued_q - outs_q);
    room  = (win > NW'(outs_q)) ? (win - NW'(outs_q)) : '0;
    num   = (avail < room) ? avail : room;
  end

  assign ram_wdata = '{seq: in_seq_q, handle: in_handle_q, len: in_len_q};

  gbn_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (ram_wdata),
    .raddr_i (rd_addr_d),
    .rdata_o (ram_rdata)
  );

  // Sequencer
  always_comb begin
    state_d       = state_q;
    win_cfg_d     = win_cfg_q;
    head_d        = head_q;
    tail_d        = tail_q;
    rd_addr_d     = rd_addr_q;
    queued_d      = queued_q;
    outs_d        = outs_q;
    cnt_d         = cnt_q;
    inc_d         = inc_q;
    pend_status_d = pend_status_q;
    pend_handle_d = pend_handle_q;
    pend_len_d    = pend_len_q;
    out_status_d  = out_status_q;
    out_handle_d  = out_handle_q;
    out_len_d     = out_len_q;
    out_last_d    = out_last_q;
    out_valid_d   = out_valid_q;
    ram_we        = 1'b0;

    // Drop the result the receiver takes
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    if (cfg_valid_i) begin
      win_cfg_d = cfg_data_i;
    end

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        case (in_mode_q)
          MODE_SEND: begin
            if (queued_q == CW'(QUEUE_DEPTH)) begin
              pend_status_d = ST_FULL;
              pend_handle_d = '0;
              pend_len_d    = '0;
              state_d       = S_PUT;
            end else begin
              ram_we   = 1'b1;
              tail_d   = ptr_add(tail_q, CW'(1));
              queued_d = queued_q + CW'(1);
              if (NW'(outs_q) < win) begin
                outs_d        = outs_q + CW'(1);
                pend_status_d = ST_TX;
                pend_handle_d = in_handle_q;
                pend_len_d    = in_len_q;
                state_d       = S_PUT;
              end else begin
                state_d = S_IDLE;
              end
            end
          end
          MODE_ACK: begin
            rd_addr_d = head_q;
            state_d   = S_ACK;
          end
          MODE_TIMEOUT: begin
            rd_addr_d = head_q;
            cnt_d     = outs_q;
            inc_d     = 1'b0;
            state_d   = (outs_q == '0) ? S_IDLE : S_EMIT;
          end
          default: begin
            pend_status_d = ST_BADMODE;
            pend_handle_d = '0;
            pend_len_d    = '0;
            state_d       = S_PUT;
          end
        endcase
      end

      // Retire one acknowledged frame per cycle from the head
      S_ACK: begin
        if (outs_q != '0 && ram_rdata.seq <= in_ack_q) begin
          head_d    = ptr_add(head_q, CW'(1));
          rd_addr_d = ptr_add(head_q, CW'(1));
          queued_d  = queued_q - CW'(1);
          outs_d    = outs_q - CW'(1);
        end else begin
          state_d = S_FILL;
        end
      end

      // Point at the first unsent frame and load the refill count
      S_FILL: begin
        rd_addr_d = ptr_add(head_q, outs_q);
        cnt_d     = CW'(num);
        inc_d     = 1'b1;
        state_d   = (num == '0) ? S_IDLE : S_EMIT;
      end

      // Send one stored frame per cycle while the output is free
      S_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = ST_TX;
          out_handle_d = ram_rdata.handle;
          out_len_d    = ram_rdata.len;
          out_last_d   = (cnt_q == CW'(1));
          cnt_d        = cnt_q - CW'(1);
          rd_addr_d    = ptr_add(rd_addr_q, CW'(1));
          if (inc_q) begin
            outs_d = outs_q + CW'(1);
          end
          if (cnt_q == CW'(1)) begin
            state_d = S_IDLE;
          end
        end
      end

      // Hand over the single result of a send or an error
      S_PUT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = pend_status_q;
          out_handle_d = pend_handle_q;
          out_len_d    = pend_len_q;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      win_cfg_q   <= WIN_RESET;
      head_q      <= '0;
      tail_q      <= '0;
      rd_addr_q   <= '0;
      queued_q    <= '0;
      outs_q      <= '0;
      cnt_q       <= '0;
      inc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      win_cfg_q   <= win_cfg_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      rd_addr_q   <= rd_addr_d;
      queued_q    <= queued_d;
      outs_q      <= outs_d;
      cnt_q       <= cnt_d;
      inc_q       <= inc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_mode_q   <= s_axis_tuser;
      in_seq_q    <= s_axis_tdata[31:0];
      in_handle_q <= s_axis_tdata[47:32];
      in_len_q    <= s_axis_tdata[55:48];
      in_ack_q    <= s_axis_tdata[87:56];
    end
    pend_status_q <= pend_status_d;
    pend_handle_q <= pend_handle_d;
    pend_len_q    <= pend_len_d;
    out_status_q  <= out_status_d;
    out_handle_q  <= out_handle_d;
    out_len_q     <= out_len_d;
    out_last_q    <= out_last_d;
  end

  // Assertions
  `ASSERT_AT(a_outs_le_queued, outs_q <= queued_q)
  `ASSERT_AT(a_queued_le_depth, queued_q <= CW'(QUEUE_DEPTH))
  `ASSERT_AT(a_empty_ptrs, (queued_q == '0) |-> (head_q == tail_q))
  `ASSERT_NEVER(a_emit_cnt, (state_q == S_EMIT) && (cnt_q == '0))

endmodule
